### src/dap_pkg.sv
// ----------------------------------------------------------------------------
// dap_pkg: shared constants, types and helpers for the dihedral angle pipeline
// Widths of every datapath stage, CORDIC arctangent table, scaling helpers.
// ----------------------------------------------------------------------------
package dap_pkg;

    localparam int COORD_BITS      = 24;
    localparam int ANGLE_FRAC_BITS = 8;

    // bond vectors keep at most 25 bits
    localparam int BSHIFT = (COORD_BITS > 24) ? (COORD_BITS - 24) : 0;
    localparam int B_W    = 25;
    localparam int P_W    = 2 * B_W;        // one cross-product term
    localparam int N_W    = P_W + 1;        // normal component
    localparam int FIT_BITS = 30;           // scaled values stay below 2^30
    localparam int NS_W   = FIT_BITS + 1;   // scaled value, signed
    localparam int Q_W    = 2 * NS_W;       // product of two scaled values
    localparam int M_W    = Q_W + 1;        // component of n1 x n2
    localparam int C_W    = Q_W + 2;        // n1 . n2
    localparam int SG_P_W = NS_W + B_W;     // one term of the sign test
    localparam int SG_W   = SG_P_W + 2;
    localparam int RAD_W  = 64;             // radicand of the square root
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int SQ_STAGES = ROOT_W / 2;  // two root bits per stage
    localparam int X_W    = 36;             // CORDIC x, y and angle accumulator
    localparam int ACC_FRAC = 24;
    localparam int CORDIC_STEPS = 25;
    localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int TORS_W = 17;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [B_W-1:0]        t_b;
    typedef logic signed [P_W-1:0]        t_p;
    typedef logic signed [N_W-1:0]        t_n;
    typedef logic signed [NS_W-1:0]       t_ns;
    typedef logic signed [Q_W-1:0]        t_q;
    typedef logic signed [C_W-1:0]        t_w;
    typedef logic signed [SG_P_W-1:0]     t_sgp;
    typedef logic signed [X_W-1:0]        t_x;

    // flags that travel with each transaction
    typedef struct packed {
        logic degen;
        logic neg;
    } t_ctl;

    localparam t_x Z_90  = X_W'(64'd90 << ACC_FRAC);
    localparam t_x Z_180 = X_W'(64'd180 << ACC_FRAC);

    // atan(2^-i) in degrees, 24 fraction bits, rounded to nearest
    function automatic t_x atan_val(input logic [4:0] i);
        t_x r;
        case (i)
            5'd0:  r = X_W'(754974720);
            5'd1:  r = X_W'(445687602);
            5'd2:  r = X_W'(235489088);
            5'd3:  r = X_W'(119537938);
            5'd4:  r = X_W'(60000934);
            5'd5:  r = X_W'(30029717);
            5'd6:  r = X_W'(15018523);
            5'd7:  r = X_W'(7509720);
            5'd8:  r = X_W'(3754917);
            5'd9:  r = X_W'(1877466);
            5'd10: r = X_W'(938734);
            5'd11: r = X_W'(469367);
            5'd12: r = X_W'(234684);
            5'd13: r = X_W'(117342);
            5'd14: r = X_W'(58671);
            5'd15: r = X_W'(29335);
            5'd16: r = X_W'(14668);
            5'd17: r = X_W'(7334);
            5'd18: r = X_W'(3667);
            5'd19: r = X_W'(1833);
            5'd20: r = X_W'(917);
            5'd21: r = X_W'(458);
            5'd22: r = X_W'(229);
            5'd23: r = X_W'(115);
            5'd24: r = X_W'(57);
            default: r = '0;
        endcase
        return r;
    endfunction

    // least right shift that brings a magnitude (given as an OR of
    // magnitudes) below 2^FIT_BITS
    function automatic logic [5:0] fit_shift(input logic [63:0] v);
        logic [6:0] bl;
        bl = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                bl = 7'(i + 1);
            end
        end
        return (bl > 7'(FIT_BITS)) ? 6'(bl - 7'(FIT_BITS)) : 6'd0;
    endfunction

endpackage

### src/dap_if.sv
// ----------------------------------------------------------------------------
// dap_if: valid/ready channels of the dihedral angle block
// Input channel carries four points, output channel one angle.
// ----------------------------------------------------------------------------
interface dap_in_if;
    logic           valid;
    logic           ready;
    dap_pkg::t_coord p1_x, p1_y, p1_z;
    dap_pkg::t_coord p2_x, p2_y, p2_z;
    dap_pkg::t_coord p3_x, p3_y, p3_z;
    dap_pkg::t_coord p4_x, p4_y, p4_z;

    modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                    p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
    modport sink   (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                    p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

interface dap_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [dap_pkg::TORS_W-1:0] torsion_deg;
    logic                             degenerate;

    modport source (output valid, torsion_deg, degenerate, input ready);
    modport sink   (input valid, torsion_deg, degenerate, output ready);
endinterface

### src/dihedral_angle_from_points_top.sv
// ----------------------------------------------------------------------------
// dihedral_angle_from_points_top: signed torsion angle of four 3-D points
// One transaction per cycle sustained while the output is taken, set by
// the fully pipelined datapath (no shared unit).
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
module dihedral_angle_from_points_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dap_in_if.sink    i_pts,
    dap_out_if.source o_res
);
    // Stage map:
    //   front  5  bond vectors, normals n1/n2, per-normal scaling
    //   mid    6  n1 x n2, n1 . n2, common scaling, sum of squares, sign test
    //   sqrt  16  |n1 x n2|, two bits per stage
    //   cordic 26 prerotation plus 25 iterations
    //   out    1  clamp, round, sign, degenerate override

    // Global stall: the whole pipe holds while the output register is full
    // and not taken. Valid bits move with the data so nothing drops.
    logic w_en;

    logic            r_out_valid;
    logic signed [dap_pkg::TORS_W-1:0] r_tors;
    logic            r_degen;

    dap_pkg::t_coord w_p [12];

    logic            w_f_valid, w_f_degen;
    dap_pkg::t_ns    w_n1 [3], w_n2 [3];
    dap_pkg::t_b     w_b2 [3];

    logic            w_m_valid;
    dap_pkg::t_ctl   w_m_ctl;
    logic [dap_pkg::RAD_W-1:0] w_rad;
    dap_pkg::t_ns    w_m_c;

    logic            w_s_valid;
    logic [dap_pkg::ROOT_W-1:0] w_root;
    dap_pkg::t_ctl   w_s_ctl;
    dap_pkg::t_ns    w_s_c;

    logic            w_c_valid;
    dap_pkg::t_x     w_z;
    dap_pkg::t_ctl   w_c_ctl;

    dap_pkg::t_x     n_zc;
    logic signed [dap_pkg::TORS_W-1:0] n_tors;

    assign w_en        = !r_out_valid || o_res.ready;
    assign i_pts.ready = w_en;

    assign w_p[0]  = i_pts.p1_x;
    assign w_p[1]  = i_pts.p1_y;
    assign w_p[2]  = i_pts.p1_z;
    assign w_p[3]  = i_pts.p2_x;
    assign w_p[4]  = i_pts.p2_y;
    assign w_p[5]  = i_pts.p2_z;
    assign w_p[6]  = i_pts.p3_x;
    assign w_p[7]  = i_pts.p3_y;
    assign w_p[8]  = i_pts.p3_z;
    assign w_p[9]  = i_pts.p4_x;
    assign w_p[10] = i_pts.p4_y;
    assign w_p[11] = i_pts.p4_z;

    dap_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pts.valid),
        .i_p     (w_p),
        .o_valid (w_f_valid),
        .o_degen (w_f_degen),
        .o_n1    (w_n1),
        .o_n2    (w_n2),
        .o_b2    (w_b2)
    );

    dap_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_degen (w_f_degen),
        .i_n1    (w_n1),
        .i_n2    (w_n2),
        .i_b2    (w_b2),
        .o_valid (w_m_valid),
        .o_ctl   (w_m_ctl),
        .o_rad   (w_rad),
        .o_c     (w_m_c)
    );

    dap_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_m_valid),
        .i_rad   (w_rad),
        .i_ctl   (w_m_ctl),
        .i_c     (w_m_c),
        .o_valid (w_s_valid),
        .o_root  (w_root),
        .o_ctl   (w_s_ctl),
        .o_c     (w_s_c)
    );

    dap_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_s     (w_root),
        .i_c     (w_s_c),
        .i_ctl   (w_s_ctl),
        .o_valid (w_c_valid),
        .o_z     (w_z),
        .o_ctl   (w_c_ctl)
    );

    // Clamp to 0..180 degrees, round half up to the output fraction, then
    // apply the sign; zero sign test keeps the angle positive; degenerate gives 0.
    always_comb begin
        dap_pkg::t_x rnd;
        if (w_z < 0) begin
            n_zc = '0;
        end else if (w_z > dap_pkg::Z_180) begin
            n_zc = dap_pkg::Z_180;
        end else begin
            n_zc = w_z;
        end
        rnd = (n_zc + (dap_pkg::t_x'(1) <<< (dap_pkg::RND_SH - 1))) >>> dap_pkg::RND_SH;
        if (w_c_ctl.degen) begin
            n_tors = '0;
        end else if (w_c_ctl.neg) begin
            n_tors = -dap_pkg::TORS_W'(rnd);
        end else begin
            n_tors = dap_pkg::TORS_W'(rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tors  <= n_tors;
            r_degen <= w_c_ctl.degen;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.torsion_deg = r_tors;
    assign o_res.degenerate  = r_degen;
endmodule

### src/dap_front.sv
// ----------------------------------------------------------------------------
// dap_front: bond vectors, plane normals and their scaling
// Five stages: differences, products, normals, shift search, shift.
// ----------------------------------------------------------------------------
module dap_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  dap_pkg::t_coord i_p [12],
    output logic            o_valid,
    output logic            o_degen,
    output dap_pkg::t_ns    o_n1 [3],
    output dap_pkg::t_ns    o_n2 [3],
    output dap_pkg::t_b     o_b2 [3]
);
    logic [4:0] r_v;

    dap_pkg::t_b  r_b1 [3], r_b2a [3], r_b3 [3];
    dap_pkg::t_b  n_b1 [3], n_b2a [3], n_b3 [3];
    dap_pkg::t_p  r_q [12], n_q [12];
    dap_pkg::t_b  r_b2b [3], r_b2c [3], r_b2d [3], r_b2e [3];
    dap_pkg::t_n  r_n1 [3], r_n2 [3], n_n1 [3], n_n2 [3];
    dap_pkg::t_n  r_m1 [3], r_m2 [3];
    logic [5:0]   r_s1, r_s2, n_s1, n_s2;
    logic         r_dg4, n_dg4, r_dg5;
    dap_pkg::t_ns r_ns1 [3], r_ns2 [3];

    // stage 1: bond vectors
    always_comb begin
        logic signed [dap_pkg::COORD_BITS:0] d1, d2, d3;
        for (int k = 0; k < 3; k++) begin
            d1 = (dap_pkg::COORD_BITS+1)'(i_p[3+k]) - (dap_pkg::COORD_BITS+1)'(i_p[k]);
            d2 = (dap_pkg::COORD_BITS+1)'(i_p[6+k]) - (dap_pkg::COORD_BITS+1)'(i_p[3+k]);
            d3 = (dap_pkg::COORD_BITS+1)'(i_p[9+k]) - (dap_pkg::COORD_BITS+1)'(i_p[6+k]);
            n_b1[k]  = dap_pkg::t_b'(d1 >>> dap_pkg::BSHIFT);
            n_b2a[k] = dap_pkg::t_b'(d2 >>> dap_pkg::BSHIFT);
            n_b3[k]  = dap_pkg::t_b'(d3 >>> dap_pkg::BSHIFT);
        end
    end

    // stage 2: cross-product terms
    always_comb begin
        int k1, k2;
        for (int k = 0; k < 3; k++) begin
            k1 = (k == 2) ? 0 : k + 1;
            k2 = (k == 0) ? 2 : k - 1;
            n_q[k]   = dap_pkg::t_p'(r_b1[k1])  * dap_pkg::t_p'(r_b2a[k2]);
            n_q[3+k] = dap_pkg::t_p'(r_b1[k2])  * dap_pkg::t_p'(r_b2a[k1]);
            n_q[6+k] = dap_pkg::t_p'(r_b2a[k1]) * dap_pkg::t_p'(r_b3[k2]);
            n_q[9+k] = dap_pkg::t_p'(r_b2a[k2]) * dap_pkg::t_p'(r_b3[k1]);
        end
    end

    // stage 3: normals
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_n1[k] = dap_pkg::t_n'(r_q[k])   - dap_pkg::t_n'(r_q[3+k]);
            n_n2[k] = dap_pkg::t_n'(r_q[6+k]) - dap_pkg::t_n'(r_q[9+k]);
        end
    end

    // stage 4: scale search, zero-normal detect
    always_comb begin
        logic [63:0] or1, or2;
        or1 = '0;
        or2 = '0;
        for (int k = 0; k < 3; k++) begin
            or1 = or1 | 64'(r_n1[k][dap_pkg::N_W-1] ? -r_n1[k] : r_n1[k]);
            or2 = or2 | 64'(r_n2[k][dap_pkg::N_W-1] ? -r_n2[k] : r_n2[k]);
        end
        n_s1  = dap_pkg::fit_shift(or1);
        n_s2  = dap_pkg::fit_shift(or2);
        n_dg4 = (or1 == '0) || (or2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1  <= n_b1;
            r_b2a <= n_b2a;
            r_b3  <= n_b3;
            r_q   <= n_q;
            r_b2b <= r_b2a;
            r_n1  <= n_n1;
            r_n2  <= n_n2;
            r_b2c <= r_b2b;
            r_m1  <= r_n1;
            r_m2  <= r_n2;
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_dg4 <= n_dg4;
            r_b2d <= r_b2c;
            r_dg5 <= r_dg4;
            r_b2e <= r_b2d;
            for (int k = 0; k < 3; k++) begin
                r_ns1[k] <= dap_pkg::t_ns'(r_m1[k] >>> r_s1);
                r_ns2[k] <= dap_pkg::t_ns'(r_m2[k] >>> r_s2);
            end
        end
    end

    assign o_valid = r_v[4];
    assign o_degen = r_dg5;
    assign o_n1    = r_ns1;
    assign o_n2    = r_ns2;
    assign o_b2    = r_b2e;
endmodule

### src/dap_mid.sv
// ----------------------------------------------------------------------------
// dap_mid: cross and dot of scaled normals, rescale, squares and sign test
// Six stages; delivers the radicand for the magnitude of n1 x n2.
// ----------------------------------------------------------------------------
module dap_mid (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic                     i_degen,
    input  dap_pkg::t_ns             i_n1 [3],
    input  dap_pkg::t_ns             i_n2 [3],
    input  dap_pkg::t_b              i_b2 [3],
    output logic                     o_valid,
    output dap_pkg::t_ctl            o_ctl,
    output logic [dap_pkg::RAD_W-1:0] o_rad,
    output dap_pkg::t_ns             o_c
);
    logic [5:0] r_v;
    logic [5:0] r_dg;

    dap_pkg::t_q  r_q [9], n_q [9];
    dap_pkg::t_w  r_w [4], n_w [4];
    dap_pkg::t_w  r_w3 [4];
    logic [5:0]   r_s, n_s;
    dap_pkg::t_ns r_ws [4];
    logic [dap_pkg::Q_W-1:0] r_sq [3];
    dap_pkg::t_sgp r_sg [3];
    dap_pkg::t_ns  r_c5;
    dap_pkg::t_b  r_b2 [4][3];
    logic [dap_pkg::RAD_W-1:0] r_rad;
    logic         r_neg;
    dap_pkg::t_ns r_c6;

    // stage 1: products for n1 x n2 and n1 . n2
    always_comb begin
        int k1, k2;
        for (int k = 0; k < 3; k++) begin
            k1 = (k == 2) ? 0 : k + 1;
            k2 = (k == 0) ? 2 : k - 1;
            n_q[k]   = dap_pkg::t_q'(i_n1[k1]) * dap_pkg::t_q'(i_n2[k2]);
            n_q[3+k] = dap_pkg::t_q'(i_n1[k2]) * dap_pkg::t_q'(i_n2[k1]);
            n_q[6+k] = dap_pkg::t_q'(i_n1[k])  * dap_pkg::t_q'(i_n2[k]);
        end
    end

    // stage 2: sums
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_w[k] = dap_pkg::t_w'(r_q[k]) - dap_pkg::t_w'(r_q[3+k]);
        end
        n_w[3] = dap_pkg::t_w'(r_q[6]) + dap_pkg::t_w'(r_q[7]) + dap_pkg::t_w'(r_q[8]);
    end

    // stage 3: common scale search
    always_comb begin
        logic [63:0] orv;
        orv = '0;
        for (int k = 0; k < 4; k++) begin
            orv = orv | 64'(r_w[k][dap_pkg::C_W-1] ? -r_w[k] : r_w[k]);
        end
        n_s = dap_pkg::fit_shift(orv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [dap_pkg::SG_W-1:0] sg;
        if (i_en) begin
            r_dg <= {r_dg[4:0], i_degen};
            r_b2[0] <= i_b2;
            for (int g = 1; g < 4; g++) begin
                r_b2[g] <= r_b2[g-1];
            end
            r_q  <= n_q;
            r_w  <= n_w;
            r_w3 <= r_w;
            r_s  <= n_s;
            // stage 4: shift
            for (int k = 0; k < 4; k++) begin
                r_ws[k] <= dap_pkg::t_ns'(r_w3[k] >>> r_s);
            end
            // stage 5: squares and sign-test terms
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= dap_pkg::Q_W'(dap_pkg::t_q'(r_ws[k]) * dap_pkg::t_q'(r_ws[k]));
                r_sg[k] <= dap_pkg::t_sgp'(r_ws[k]) * dap_pkg::t_sgp'(r_b2[3][k]);
            end
            r_c5 <= r_ws[3];
            // stage 6: radicand and sign
            r_rad <= dap_pkg::RAD_W'(r_sq[0]) + dap_pkg::RAD_W'(r_sq[1])
                   + dap_pkg::RAD_W'(r_sq[2]);
            sg = dap_pkg::SG_W'(r_sg[0]) + dap_pkg::SG_W'(r_sg[1]) + dap_pkg::SG_W'(r_sg[2]);
            r_neg <= sg[dap_pkg::SG_W-1];
            r_c6  <= r_c5;
        end
    end

    assign o_valid     = r_v[5];
    assign o_ctl.degen = r_dg[5];
    assign o_ctl.neg   = r_neg;
    assign o_rad       = r_rad;
    assign o_c         = r_c6;
endmodule

### src/dap_sqrt.sv
// ----------------------------------------------------------------------------
// dap_sqrt: pipelined integer square root, floor result
// Digit-by-digit restoring method, two root bits per stage.
// ----------------------------------------------------------------------------
module dap_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [dap_pkg::RAD_W-1:0]  i_rad,
    input  dap_pkg::t_ctl              i_ctl,
    input  dap_pkg::t_ns               i_c,
    output logic                       o_valid,
    output logic [dap_pkg::ROOT_W-1:0] o_root,
    output dap_pkg::t_ctl              o_ctl,
    output dap_pkg::t_ns               o_c
);
    typedef struct packed {
        logic [dap_pkg::REM_W-1:0]  rem;
        logic [dap_pkg::ROOT_W-1:0] root;
        logic [dap_pkg::RAD_W-1:0]  rad;
    } t_sq;

    function automatic t_sq sq_step(input t_sq a);
        t_sq r;
        logic [dap_pkg::REM_W-1:0] cur, trial;
        cur   = {a.rem[dap_pkg::REM_W-3:0], a.rad[dap_pkg::RAD_W-1 -: 2]};
        trial = {1'b0, a.root, 2'b01};
        r.rad = {a.rad[dap_pkg::RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {a.root[dap_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {a.root[dap_pkg::ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    t_sq           r_st  [dap_pkg::SQ_STAGES];
    dap_pkg::t_ctl r_ctl [dap_pkg::SQ_STAGES];
    dap_pkg::t_ns  r_c   [dap_pkg::SQ_STAGES];
    logic [dap_pkg::SQ_STAGES-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[dap_pkg::SQ_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        t_sq s0;
        if (i_en) begin
            s0.rem  = '0;
            s0.root = '0;
            s0.rad  = i_rad;
            r_st[0]  <= sq_step(sq_step(s0));
            r_ctl[0] <= i_ctl;
            r_c[0]   <= i_c;
            for (int g = 1; g < dap_pkg::SQ_STAGES; g++) begin
                r_st[g]  <= sq_step(sq_step(r_st[g-1]));
                r_ctl[g] <= r_ctl[g-1];
                r_c[g]   <= r_c[g-1];
            end
        end
    end

    assign o_valid = r_v[dap_pkg::SQ_STAGES-1];
    assign o_root  = r_st[dap_pkg::SQ_STAGES-1].root;
    assign o_ctl   = r_ctl[dap_pkg::SQ_STAGES-1];
    assign o_c     = r_c[dap_pkg::SQ_STAGES-1];
endmodule

### src/dap_cordic.sv
// ----------------------------------------------------------------------------
// dap_cordic: vectoring CORDIC for atan2(s, c) in degrees
// Quarter-turn prerotation stage, then one iteration per stage.
// ----------------------------------------------------------------------------
module dap_cordic (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [dap_pkg::ROOT_W-1:0] i_s,
    input  dap_pkg::t_ns               i_c,
    input  dap_pkg::t_ctl              i_ctl,
    output logic                       o_valid,
    output dap_pkg::t_x                o_z,
    output dap_pkg::t_ctl              o_ctl
);
    localparam int NST = dap_pkg::CORDIC_STEPS + 1;

    dap_pkg::t_x   r_x [NST], r_y [NST], r_z [NST];
    dap_pkg::t_ctl r_ctl [NST];
    logic [NST-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // negative cosine: rotate by a quarter turn first
            if (i_c[dap_pkg::NS_W-1]) begin
                r_x[0] <= dap_pkg::t_x'({1'b0, i_s});
                r_y[0] <= -dap_pkg::t_x'(i_c);
                r_z[0] <= dap_pkg::Z_90;
            end else begin
                r_x[0] <= dap_pkg::t_x'(i_c);
                r_y[0] <= dap_pkg::t_x'({1'b0, i_s});
                r_z[0] <= '0;
            end
            r_ctl[0] <= i_ctl;
            for (int i = 0; i < dap_pkg::CORDIC_STEPS; i++) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + dap_pkg::atan_val(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - dap_pkg::atan_val(5'(i));
                end
                r_ctl[i+1] <= r_ctl[i];
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_z     = r_z[NST-1];
    assign o_ctl   = r_ctl[NST-1];
endmodule
